/* sv/gdda_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdda_pkg
// Shared widths, opcodes, calendar tables and controller/datapath structs for
// the Gregorian date day arithmetic block.
// ----------------------------------------------------------------------------
`default_nettype none

package gdda_pkg;

	localparam int unsigned OP_W      = 2;
	localparam int unsigned CNT_W     = 16;
	localparam int unsigned YEAR_W    = 12;
	localparam int unsigned MONTH_W   = 4;
	localparam int unsigned DAY_W     = 5;
	localparam int unsigned OUT_DN_W  = 20;
	// internal day number: wide enough for year 4095 with the earliest epoch
	localparam int unsigned DN_W      = 21;
	localparam int unsigned PART_W    = 9;
	localparam int unsigned Q100_W    = 6;

	localparam int unsigned IN_BITS   = OP_W + CNT_W + YEAR_W + MONTH_W + DAY_W;
	localparam int unsigned OUT_BITS  = YEAR_W + MONTH_W + DAY_W + 2 * OUT_DN_W + 5;
	localparam int unsigned S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam int unsigned EPOCH_YEAR_DEF = 1990;
	localparam int unsigned MAX_YEAR       = 4095;
	localparam int unsigned MONTHS         = 12;
	localparam int unsigned DAYS_PER_YEAR  = 365;
	// x / 100 == (x * RECIP_100) >> RECIP_SHIFT for every 12-bit x
	localparam int unsigned RECIP_100      = 5243;
	localparam int unsigned RECIP_SHIFT    = 19;
	localparam int unsigned PROD_W         = YEAR_W + 13;

	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD  = 2'd1;
	localparam logic [OP_W-1:0] OP_SUB  = 2'd2;
	localparam logic [OP_W-1:0] OP_CMP  = 2'd3;

	typedef struct packed {
		logic capture;
		logic sat_day;
		logic load_date;
		logic add_step;
		logic sub_step;
		logic commit;
		logic dn_src_oth;
		logic dn_store_oth;
		logic dn_store_cur;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            cnt_zero;
		logic            oor;
	} dp_sts_t;

	// divisible by 4, centuries only when divisible by 400
	function automatic logic leap_year(input logic [YEAR_W-1:0] y);
		logic [PROD_W-1:0] prod;
		logic              div100;
		prod   = PROD_W'(y) * PROD_W'(RECIP_100);
		div100 = (prod[RECIP_SHIFT-1:0] < RECIP_SHIFT'(RECIP_100));
		return (y[1:0] == 2'd0) && (!div100 || (prod[RECIP_SHIFT+1:RECIP_SHIFT] == 2'd0));
	endfunction

	function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m, input logic leap);
		logic [DAY_W-1:0] n;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
			4'd2:                                       n = leap ? 5'd29 : 5'd28;
			default:                                    n = 5'd0;
		endcase
		return n;
	endfunction

	// days of a common year before the first of month m
	function automatic logic [PART_W-1:0] days_before(input logic [MONTH_W-1:0] m);
		logic [PART_W-1:0] n;
		unique case (m)
			4'd1:    n = 9'd0;
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

/* sv/gdda_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdda_ctrl
// Sequencer: saturates the input date, runs the month walk for add and
// subtract, drives the day number unit and hands results to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gdda_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	input  wire gdda_pkg::dp_sts_t sts,
	output gdda_pkg::dp_cmd_t      cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SAT1   = 4'd1;
	localparam logic [3:0] ST_SAT2   = 4'd2;
	localparam logic [3:0] ST_LOAD   = 4'd3;
	localparam logic [3:0] ST_ADD    = 4'd4;
	localparam logic [3:0] ST_SUB    = 4'd5;
	localparam logic [3:0] ST_COMMIT = 4'd6;
	localparam logic [3:0] ST_SETTLE = 4'd7;
	localparam logic [3:0] ST_OTH_A  = 4'd8;
	localparam logic [3:0] ST_OTH_B  = 4'd9;
	localparam logic [3:0] ST_DN_A   = 4'd10;
	localparam logic [3:0] ST_DN_B   = 4'd11;
	localparam logic [3:0] ST_OUT    = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       m_tvalid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_SAT1;
				end
			end
			// leap flag of the input year settles here
			ST_SAT1: state_nxt = ST_SAT2;
			ST_SAT2: begin
				cmd.sat_day = 1'b1;
				unique case (sts.op)
					gdda_pkg::OP_LOAD: state_nxt = ST_LOAD;
					gdda_pkg::OP_ADD:  state_nxt = ST_ADD;
					gdda_pkg::OP_SUB:  state_nxt = ST_SUB;
					gdda_pkg::OP_CMP:  state_nxt = ST_OTH_A;
					default:           state_nxt = ST_LOAD;
				endcase
			end
			ST_LOAD: begin
				cmd.load_date = 1'b1;
				state_nxt     = ST_SETTLE;
			end
			ST_ADD: begin
				if (sts.cnt_zero || sts.oor) begin
					state_nxt = ST_COMMIT;
				end else begin
					cmd.add_step = 1'b1;
				end
			end
			ST_SUB: begin
				if (sts.cnt_zero || sts.oor) begin
					state_nxt = ST_COMMIT;
				end else begin
					cmd.sub_step = 1'b1;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_nxt  = ST_SETTLE;
			end
			// leap flag of the stored year catches up with a changed year
			ST_SETTLE: state_nxt = ST_DN_A;
			ST_OTH_A: begin
				cmd.dn_src_oth = 1'b1;
				state_nxt      = ST_OTH_B;
			end
			ST_OTH_B: begin
				cmd.dn_store_oth = 1'b1;
				state_nxt        = ST_DN_A;
			end
			ST_DN_A: state_nxt = ST_DN_B;
			ST_DN_B: begin
				cmd.dn_store_cur = 1'b1;
				state_nxt        = ST_OUT;
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("result loaded over an untaken result");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after a transaction");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result withdrawn before its transaction");
`endif

endmodule

`default_nettype wire

/* sv/gdda_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdda_dp
// Datapath: input capture and saturation, stored date with committed copy,
// one month per add/subtract step, two-stage day number unit, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gdda_dp #(
	parameter int unsigned EPOCH_YEAR = gdda_pkg::EPOCH_YEAR_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [gdda_pkg::S_TDATA_W-1:0]   in_data,
	input  wire gdda_pkg::dp_cmd_t                cmd,
	output gdda_pkg::dp_sts_t                     sts,
	output logic      [gdda_pkg::M_TDATA_W-1:0]   res_data
);

	localparam int unsigned YW = gdda_pkg::YEAR_W;
	localparam int unsigned MW = gdda_pkg::MONTH_W;
	localparam int unsigned DW = gdda_pkg::DAY_W;
	localparam int unsigned CW = gdda_pkg::CNT_W;
	localparam int unsigned NW = gdda_pkg::DN_W;

	localparam logic [YW-1:0] EPOCH    = YW'(EPOCH_YEAR);
	localparam logic [YW-1:0] YEAR_TOP = YW'(gdda_pkg::MAX_YEAR);
	localparam logic [MW-1:0] DEC      = MW'(gdda_pkg::MONTHS);
	localparam int unsigned   EPM1     = EPOCH_YEAR - 1;
	localparam logic [NW-1:0] LEAPS_BASE = NW'(EPM1 / 4 - EPM1 / 100 + EPM1 / 400);

	// input fields
	logic [gdda_pkg::OP_W-1:0] in_op;
	logic [CW-1:0]             in_cnt;
	logic [YW-1:0]             in_year;
	logic [MW-1:0]             in_month;
	logic [DW-1:0]             in_day;

	assign in_op    = in_data[1:0];
	assign in_cnt   = in_data[17:2];
	assign in_year  = in_data[29:18];
	assign in_month = in_data[33:30];
	assign in_day   = in_data[38:34];

	logic [gdda_pkg::OP_W-1:0] op_q;
	logic [CW-1:0]             cnt_q;
	logic [YW-1:0]             oy_q;
	logic [MW-1:0]             om_q;
	logic [DW-1:0]             od_q;
	logic                      leap_o_q;
	logic                      leap_q;
	logic                      oor_q;

	// working date and committed date
	logic [YW-1:0] y_q, sy_q;
	logic [MW-1:0] m_q, sm_q;
	logic [DW-1:0] d_q, sd_q;

	// month step
	logic [DW-1:0]   lim_cur;
	logic [DW-1:0]   lim_prev;
	logic [MW-1:0]   m_prev;
	logic [CW:0]     add_sum;
	logic            add_fits;
	logic            sub_fits;
	logic [DW-1:0]   lim_oth;

	always_comb begin
		lim_cur  = gdda_pkg::days_in(m_q, leap_q);
		m_prev   = m_q - MW'(1);
		lim_prev = gdda_pkg::days_in(m_prev, leap_q);
		add_sum  = (CW+1)'(d_q) + (CW+1)'(cnt_q);
		add_fits = (add_sum <= (CW+1)'(lim_cur));
		sub_fits = (CW'(d_q) > cnt_q);
		lim_oth  = gdda_pkg::days_in(om_q, leap_o_q);
	end

	assign sts.op       = op_q;
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.oor      = oor_q;

	always_ff @(posedge clk) begin
		leap_q   <= gdda_pkg::leap_year(y_q);
		leap_o_q <= gdda_pkg::leap_year(oy_q);
		if (cmd.capture) begin
			op_q  <= in_op;
			cnt_q <= in_cnt;
			oy_q  <= (in_year < EPOCH) ? EPOCH : in_year;
			if (in_month == '0) begin
				om_q <= MW'(1);
			end else if (in_month > DEC) begin
				om_q <= DEC;
			end else begin
				om_q <= in_month;
			end
			od_q  <= in_day;
		end else if (cmd.sat_day) begin
			if (od_q == '0) begin
				od_q <= DW'(1);
			end else if (od_q > lim_oth) begin
				od_q <= lim_oth;
			end
		end else if (cmd.add_step) begin
			cnt_q <= add_fits ? '0 : cnt_q - CW'(lim_cur - d_q + DW'(1));
		end else if (cmd.sub_step) begin
			cnt_q <= sub_fits ? '0 : cnt_q - CW'(d_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_q   <= EPOCH;
			m_q   <= MW'(1);
			d_q   <= DW'(1);
			sy_q  <= EPOCH;
			sm_q  <= MW'(1);
			sd_q  <= DW'(1);
			oor_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				oor_q <= 1'b0;
			end
			if (cmd.load_date) begin
				y_q  <= oy_q;
				m_q  <= om_q;
				d_q  <= od_q;
				sy_q <= oy_q;
				sm_q <= om_q;
				sd_q <= od_q;
			end else if (cmd.add_step) begin
				if (add_fits) begin
					d_q <= add_sum[DW-1:0];
				end else begin
					d_q <= DW'(1);
					if (m_q == DEC) begin
						m_q <= MW'(1);
						if (y_q == YEAR_TOP) begin
							oor_q <= 1'b1;
						end else begin
							y_q <= y_q + YW'(1);
						end
					end else begin
						m_q <= m_q + MW'(1);
					end
				end
			end else if (cmd.sub_step) begin
				if (sub_fits) begin
					d_q <= d_q - cnt_q[DW-1:0];
				end else if (m_q <= MW'(1)) begin
					m_q <= DEC;
					d_q <= gdda_pkg::days_in(DEC, leap_q);
					if (y_q <= EPOCH) begin
						oor_q <= 1'b1;
					end else begin
						y_q <= y_q - YW'(1);
					end
				end else begin
					m_q <= m_prev;
					d_q <= lim_prev;
				end
			end else if (cmd.commit) begin
				if (oor_q) begin
					y_q <= sy_q;
					m_q <= sm_q;
					d_q <= sd_q;
				end else begin
					sy_q <= y_q;
					sm_q <= m_q;
					sd_q <= d_q;
				end
			end
		end
	end

	// day number unit, stage 1: the two multiplications and the in-year part
	logic [YW-1:0]                      src_y;
	logic [MW-1:0]                      src_m;
	logic [DW-1:0]                      src_d;
	logic                               src_leap;
	logic [YW-1:0]                      ym1;
	logic [gdda_pkg::PROD_W-1:0]        prod100;

	logic [YW-1:0]                      ym1_s1;
	logic [gdda_pkg::Q100_W-1:0]        q100_s1;
	logic [NW-1:0]                      mul365_s1;
	logic [gdda_pkg::PART_W-1:0]        part_s1;
	logic [NW-1:0]                      dn_sum;
	logic [NW-1:0]                      dn_cur_q;
	logic [NW-1:0]                      dn_oth_q;

	always_comb begin
		src_y    = cmd.dn_src_oth ? oy_q     : y_q;
		src_m    = cmd.dn_src_oth ? om_q     : m_q;
		src_d    = cmd.dn_src_oth ? od_q     : d_q;
		src_leap = cmd.dn_src_oth ? leap_o_q : leap_q;
		ym1      = src_y - YW'(1);
		prod100  = gdda_pkg::PROD_W'(ym1) * gdda_pkg::PROD_W'(gdda_pkg::RECIP_100);
	end

	always_ff @(posedge clk) begin
		ym1_s1    <= ym1;
		q100_s1   <= prod100[gdda_pkg::RECIP_SHIFT+gdda_pkg::Q100_W-1:gdda_pkg::RECIP_SHIFT];
		mul365_s1 <= NW'(src_y - EPOCH) * NW'(gdda_pkg::DAYS_PER_YEAR);
		part_s1   <= gdda_pkg::days_before(src_m)
			+ gdda_pkg::PART_W'(src_leap && (src_m > MW'(2)))
			+ gdda_pkg::PART_W'(src_d);
	end

	// stage 2: year days, in-year part and leap days up to the previous year, minus those before the epoch
	assign dn_sum = mul365_s1 + NW'(ym1_s1 >> 2) - NW'(q100_s1) + NW'(q100_s1 >> 2)
		- LEAPS_BASE + NW'(part_s1);

	// result register
	logic                                is_cmp;
	logic [gdda_pkg::OUT_DN_W-1:0]       diff;
	logic [gdda_pkg::M_TDATA_W-1:0]      res_q;

	always_comb begin
		is_cmp = (op_q == gdda_pkg::OP_CMP);
		diff   = '0;
		if (is_cmp && (dn_cur_q >= dn_oth_q)) begin
			diff = gdda_pkg::OUT_DN_W'(dn_cur_q - dn_oth_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dn_store_oth) begin
			dn_oth_q <= dn_sum;
		end
		if (cmd.dn_store_cur) begin
			dn_cur_q <= dn_sum;
		end
		if (cmd.out_load) begin
			res_q <= {
				(gdda_pkg::M_TDATA_W - gdda_pkg::OUT_BITS)'(0),
				oor_q,
				is_cmp && (dn_cur_q > dn_oth_q),
				is_cmp && (dn_cur_q < dn_oth_q),
				is_cmp && (dn_cur_q == dn_oth_q),
				is_cmp && (dn_oth_q > dn_cur_q),
				diff,
				dn_cur_q[gdda_pkg::OUT_DN_W-1:0],
				d_q,
				m_q,
				y_q
			};
		end
	end

	assign res_data = res_q;

`ifndef ASSERT_OFF
	a_date_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_date || cmd.add_step || cmd.sub_step || cmd.commit)
		|=> ($stable(y_q) && $stable(m_q) && $stable(d_q)))
		else $error("stored date moved without a command");

	a_date_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_q >= MW'(1)) && (m_q <= DEC) && (d_q >= DW'(1)) && (y_q >= EPOCH))
		else $error("stored date outside its field ranges");

	a_oor_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(oor_q) |-> $past(cmd.add_step || cmd.sub_step))
		else $error("range flag set outside a month step");
`endif

endmodule

`default_nettype wire

/* sv/gregorian_date_day_arithmetic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_day_arithmetic
// Holds a Gregorian date; loads it, adds or subtracts days, or compares it
// with another date, returning the date, its day number and compare flags.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_axis   | in        | opcode, day_count, other_year, other_month, other_day
//  m_axis   | out       | stored date, day_number, difference, order and range flags
//
//  load and compare pass through input saturation and the day number unit;
//  add and subtract first walk the date one month per step, set by the
//  single-month step of the date registers; a nonzero count takes at least
//  one step
//  reset leaves the stored date at 1 January of the epoch year
//  one item at a time; the next one is taken while a result waits at m_axis
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_day_arithmetic #(
	parameter int unsigned EPOCH_YEAR = gdda_pkg::EPOCH_YEAR_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// opcode[1:0], day_count[17:2], other_year[29:18], other_month[33:30],
	// other_day[38:34], zero fill above
	input  wire logic [gdda_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// cur_year[11:0], cur_month[15:12], cur_day[20:16], day_number[40:21],
	// difference[60:41], invalid_order[61], is_equal[62], is_less[63],
	// is_greater[64], out_of_range[65], zero fill above
	output logic      [gdda_pkg::M_TDATA_W-1:0] m_tdata
);

	gdda_pkg::dp_cmd_t cmd;
	gdda_pkg::dp_sts_t sts;

	gdda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gdda_dp #(
		.EPOCH_YEAR (EPOCH_YEAR)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.res_data (m_tdata)
	);

endmodule

`default_nettype wire
